FILE: sv/srx_pkg.sv
// srx_pkg: types and constants shared by the serial receive silo modules
// no dependencies; used by srx_front, srx_queue, srx_back and the top level
package srx_pkg;

   localparam int WAKE_CNT_W = 5;
   localparam logic [WAKE_CNT_W-1:0] WAKE_LIMIT = 5'd20;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] STOP_CHAR_RST = 7'd19;
   localparam logic [7:0] INTR_CHAR_RST = 8'd127;

   // configuration register indexes
   localparam logic [2:0] CSR_STOP_CHAR    = 3'd0;
   localparam logic [2:0] CSR_INTR_CHAR    = 3'd1;
   localparam logic [2:0] CSR_RAW_MODE     = 3'd2;
   localparam logic [2:0] CSR_MOUSE_MODE   = 3'd3;
   localparam logic [2:0] CSR_SOFT_CARRIER = 3'd4;
   localparam logic [2:0] CSR_DIALOUT_LINE = 3'd5;
   localparam logic [2:0] CSR_NO_HANGUP    = 3'd6;
   localparam logic [2:0] CSR_LINE_OPEN    = 3'd7;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_ERROR   = 2'd1,
      CMD_STATUS  = 2'd2,
      CMD_SERVICE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACK      = 3'd0,
      KIND_BYTE     = 3'd1,
      KIND_CARRIER  = 3'd2,
      KIND_HANGUP   = 3'd3,
      KIND_OVERFLOW = 3'd4,
      KIND_BREAK    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CAR,
      ST_OVF,
      ST_BRK,
      ST_READ,
      ST_BYTE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [6:0] stop_char;
      logic [7:0] intr_char;
      logic       raw_mode;
      logic       mouse_mode;
      logic       soft_carrier;
      logic       dialout_line;
      logic       no_hangup;
      logic       line_open;
   } cfg_type;

   // one classified transaction on its way from front to back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] rx_byte;
      logic       is_null;
      logic       is_stop;
      logic       brk;
      logic       car;
      logic       dovr;
   } item_type;

endpackage

FILE: sv/serial_rx_silo_with_line_events.sv
// serial_rx_silo_with_line_events: top level, configuration registers and assertions
// depends on srx_pkg, srx_front, srx_queue, srx_back
//
// Receive silo for a serial line. Byte, receive-error and status-change
// transactions each give one result from the back end once they reach the
// head of the two-entry queue; the queue lets the front keep accepting while
// a result waits on rsp_stall. A service pass (command 3) takes a planning
// step, one result per carrier, overflow or break event, and per drained byte
// a registered read of the ring memory, then the result (none while the line
// is closed), up to the drain limit of 20 by default; a pass with no other
// result closes with an acknowledge. rsp_stall can hold each result. The ring
// needs no clearing pass after reset: its pointers start equal and an
// overflow flush returns both to zero.
module serial_rx_silo_with_line_events #(
   parameter int RING_DEPTH  = 256,
   parameter int DRAIN_LIMIT = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_rx_byte,
   input  logic       req_break_now,
   input  logic       req_carrier_now,
   input  logic       req_data_overrun,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_wake,
   output logic       rsp_more_pending,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   srx_pkg::cfg_type  cfg_ff, cfg_in;
   srx_pkg::item_type push_item;
   srx_pkg::item_type head_item;
   logic q_push;
   logic q_pop;
   logic q_full;
   logic q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            srx_pkg::CSR_STOP_CHAR:    cfg_in.stop_char    = csr_wdata[6:0];
            srx_pkg::CSR_INTR_CHAR:    cfg_in.intr_char    = csr_wdata;
            srx_pkg::CSR_RAW_MODE:     cfg_in.raw_mode     = csr_wdata[0];
            srx_pkg::CSR_MOUSE_MODE:   cfg_in.mouse_mode   = csr_wdata[0];
            srx_pkg::CSR_SOFT_CARRIER: cfg_in.soft_carrier = csr_wdata[0];
            srx_pkg::CSR_DIALOUT_LINE: cfg_in.dialout_line = csr_wdata[0];
            srx_pkg::CSR_NO_HANGUP:    cfg_in.no_hangup    = csr_wdata[0];
            srx_pkg::CSR_LINE_OPEN:    cfg_in.line_open    = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_char    <= srx_pkg::STOP_CHAR_RST;
         cfg_ff.intr_char    <= srx_pkg::INTR_CHAR_RST;
         cfg_ff.raw_mode     <= 1'b0;
         cfg_ff.mouse_mode   <= 1'b0;
         cfg_ff.soft_carrier <= 1'b0;
         cfg_ff.dialout_line <= 1'b0;
         cfg_ff.no_hangup    <= 1'b0;
         cfg_ff.line_open    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srx_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .req_break_now    (req_break_now),
      .req_carrier_now  (req_carrier_now),
      .req_data_overrun (req_data_overrun),
      .stop_char        (cfg_ff.stop_char),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   srx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   srx_back #(
      .RING_DEPTH  (RING_DEPTH),
      .DRAIN_LIMIT (DRAIN_LIMIT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_not_empty      (q_not_empty),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_wake         (rsp_wake),
      .rsp_more_pending (rsp_more_pending),
      .rsp_last         (rsp_last)
   );

   // service event results never carry a wake request
   a_no_wake_on_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != srx_pkg::KIND_ACK |-> !rsp_wake)
      else $error("wake set on a service event transaction");

   // more-pending only on the closing result of a transaction
   a_more_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_more_pending |-> rsp_last)
      else $error("more_pending set on a non-final result");

   // only byte and break results carry data
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != srx_pkg::KIND_BYTE && rsp_kind != srx_pkg::KIND_BREAK
      |-> rsp_out_byte == 8'd0)
      else $error("out_byte nonzero on a result without data");

   // the queue never pops what it does not hold
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("back end popped an empty queue");

endmodule

FILE: sv/srx_front.sv
// srx_front: accepts request transactions and classifies them for the back end
// depends on srx_pkg
module srx_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_break_now,
   input  logic               req_carrier_now,
   input  logic               req_data_overrun,
   input  logic [6:0]         stop_char,
   input  logic               q_full,
   output logic               q_push,
   output srx_pkg::item_type  q_item
);

   srx_pkg::cmd_type cmd;

   always_comb begin
      unique case (req_command)
         2'd0:    cmd = srx_pkg::CMD_BYTE;
         2'd1:    cmd = srx_pkg::CMD_ERROR;
         2'd2:    cmd = srx_pkg::CMD_STATUS;
         default: cmd = srx_pkg::CMD_SERVICE;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.cmd     = cmd;
      q_item.rx_byte = req_rx_byte;
      q_item.is_null = (req_rx_byte == 8'd0);
      // stop character matches on the low seven bits only
      q_item.is_stop = (req_rx_byte[6:0] == stop_char);
      q_item.brk     = req_break_now;
      q_item.car     = req_carrier_now;
      q_item.dovr    = req_data_overrun;
   end

endmodule

FILE: sv/srx_queue.sv
// srx_queue: short queue of classified transactions between front and back
// depends on srx_pkg
module srx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  srx_pkg::item_type  push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output srx_pkg::item_type  head_item
);

   localparam int PTR_W = (srx_pkg::QUEUE_DEPTH > 1) ? $clog2(srx_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(srx_pkg::QUEUE_DEPTH + 1);

   srx_pkg::item_type entry_ff [srx_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      ptr_step = (p == PTR_W'(srx_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(srx_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/srx_back.sv
// srx_back: ring store, line state and service pass sequencer with result register
// depends on srx_pkg
module srx_back #(
   parameter int RING_DEPTH  = 256,
   parameter int DRAIN_LIMIT = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  srx_pkg::cfg_type   cfg,
   input  logic               q_not_empty,
   input  srx_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_wake,
   output logic               rsp_more_pending,
   output logic               rsp_last
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(DRAIN_LIMIT + 1);
   localparam int OCC_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;

   logic [7:0] ring_mem [RING_DEPTH];
   logic       mem_wr;
   logic       mem_rd;
   logic [7:0] rd_data_ff;

   srx_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0]               wp_ff, wp_in, wp_nxt;
   logic [PTR_W-1:0]               rp_ff, rp_in, rp_nxt;
   logic [srx_pkg::WAKE_CNT_W-1:0] wake_cnt_ff, wake_cnt_in, wake_cnt_inc;
   logic saved_brk_ff, saved_brk_in;
   logic brk_pend_ff, brk_pend_in;
   logic stat_pend_ff, stat_pend_in;
   logic ovr_pend_ff, ovr_pend_in;
   logic carrier_on_ff, carrier_on_in;

   // service pass plan: line flags taken with the request, the rest set in the prep step
   logic             svc_brk_ff, svc_brk_in;
   logic             svc_car_ff, svc_car_in;
   logic             car_e_ff, car_e_in;
   logic             car_up_ff, car_up_in;
   logic             ovf_e_ff, ovf_e_in;
   logic             brk_e_ff, brk_e_in;
   logic             more_ff, more_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] drain_cnt_ff, drain_cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_wake_ff, rsp_wake_in;
   logic       rsp_more_ff, rsp_more_in;
   logic       rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             bytes_e;
   logic             car_present;
   logic             wake;
   logic [OCC_W-1:0] occ;
   logic             occ_more;

   assign wp_nxt   = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_nxt   = (rp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bytes_e  = cfg.line_open && (drain_cnt_ff != '0);
   assign car_present  = svc_car_ff || cfg.soft_carrier || cfg.dialout_line;
   assign wake_cnt_inc = wake_cnt_ff + 1'b1;
   assign occ = (wp_ff >= rp_ff) ? OCC_W'(wp_ff) - OCC_W'(rp_ff)
                                 : OCC_W'(wp_ff) + OCC_W'(RING_DEPTH) - OCC_W'(rp_ff);
   assign occ_more = (occ > OCC_W'(DRAIN_LIMIT));

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      wake_cnt_in   = wake_cnt_ff;
      saved_brk_in  = saved_brk_ff;
      brk_pend_in   = brk_pend_ff;
      stat_pend_in  = stat_pend_ff;
      ovr_pend_in   = ovr_pend_ff;
      carrier_on_in = carrier_on_ff;
      svc_brk_in    = svc_brk_ff;
      svc_car_in    = svc_car_ff;
      car_e_in      = car_e_ff;
      car_up_in     = car_up_ff;
      ovf_e_in      = ovf_e_ff;
      brk_e_in      = brk_e_ff;
      more_in       = more_ff;
      done_in       = done_ff;
      drain_cnt_in  = drain_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_more_in   = rsp_more_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      wake          = 1'b0;

      unique case (state_ff)
         srx_pkg::ST_IDLE: begin
            q_pop = q_not_empty && (q_item.cmd == srx_pkg::CMD_SERVICE || out_free);
            if (q_pop) begin
               unique case (q_item.cmd)
                  srx_pkg::CMD_BYTE: begin
                     rsp_valid_in = 1'b1;
                     // null byte while the break is still held is dropped
                     if (!(q_item.is_null && saved_brk_ff && q_item.brk)) begin
                        if (q_item.is_null && saved_brk_ff) begin
                           brk_pend_in  = 1'b1;
                           saved_brk_in = 1'b0;
                           stat_pend_in = 1'b1;
                           wake         = 1'b1;
                        end
                        mem_wr = 1'b1;
                        wp_in  = wp_nxt;
                        if (wp_nxt == rp_ff) begin
                           ovr_pend_in = 1'b1;
                        end
                        if (cfg.mouse_mode || q_item.is_stop ||
                            wake_cnt_inc > srx_pkg::WAKE_LIMIT) begin
                           wake_cnt_in = '0;
                           wake        = 1'b1;
                        end else begin
                           wake_cnt_in = wake_cnt_inc;
                        end
                     end
                  end
                  srx_pkg::CMD_ERROR: begin
                     rsp_valid_in = 1'b1;
                     if (q_item.dovr) begin
                        ovr_pend_in = 1'b1;
                        wake        = 1'b1;
                     end
                  end
                  srx_pkg::CMD_STATUS: begin
                     rsp_valid_in = 1'b1;
                     if (saved_brk_ff && !q_item.brk) begin
                        brk_pend_in = 1'b1;
                     end
                     saved_brk_in = q_item.brk;
                     stat_pend_in = 1'b1;
                     wake         = 1'b1;
                  end
                  default: begin
                     svc_brk_in = q_item.brk;
                     svc_car_in = q_item.car;
                     state_in   = srx_pkg::ST_PREP;
                  end
               endcase
               // a service pass leaves a waiting result untouched
               if (q_item.cmd != srx_pkg::CMD_SERVICE) begin
                  rsp_kind_in = srx_pkg::KIND_ACK;
                  rsp_byte_in = 8'd0;
                  rsp_more_in = 1'b0;
                  rsp_last_in = 1'b1;
                  rsp_wake_in = wake;
               end
            end
         end

         srx_pkg::ST_PREP: begin
            car_up_in = car_present;
            car_e_in  = stat_pend_ff && (car_present ? !carrier_on_ff
                                                     : carrier_on_ff && !cfg.no_hangup);
            if (stat_pend_ff) begin
               stat_pend_in  = 1'b0;
               carrier_on_in = car_present;
            end
            ovf_e_in = ovr_pend_ff && cfg.line_open;
            brk_e_in = brk_pend_ff && !svc_brk_ff && cfg.line_open;
            if (brk_pend_ff && !svc_brk_ff) begin
               brk_pend_in = 1'b0;
            end
            if (ovr_pend_ff) begin
               // flush: pointers back to zero, nothing left to drain
               ovr_pend_in  = 1'b0;
               wp_in        = '0;
               rp_in        = '0;
               more_in      = 1'b0;
               drain_cnt_in = '0;
            end else begin
               more_in      = occ_more;
               drain_cnt_in = occ_more ? CNT_W'(DRAIN_LIMIT) : CNT_W'(occ);
            end
            done_in = !(car_e_in || ovf_e_in || brk_e_in ||
                        (cfg.line_open && drain_cnt_in != '0));
            if (car_e_in) begin
               state_in = srx_pkg::ST_CAR;
            end else if (ovf_e_in) begin
               state_in = srx_pkg::ST_OVF;
            end else if (brk_e_in) begin
               state_in = srx_pkg::ST_BRK;
            end else if (drain_cnt_in != '0) begin
               state_in = srx_pkg::ST_READ;
            end else begin
               state_in = srx_pkg::ST_DONE;
            end
         end

         srx_pkg::ST_CAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = car_up_ff ? srx_pkg::KIND_CARRIER : srx_pkg::KIND_HANGUP;
               rsp_byte_in  = 8'd0;
               rsp_wake_in  = 1'b0;
               rsp_last_in  = !(ovf_e_ff || brk_e_ff || bytes_e);
               rsp_more_in  = rsp_last_in && more_ff;
               if (ovf_e_ff) begin
                  state_in = srx_pkg::ST_OVF;
               end else if (brk_e_ff) begin
                  state_in = srx_pkg::ST_BRK;
               end else if (drain_cnt_ff != '0) begin
                  state_in = srx_pkg::ST_READ;
               end else begin
                  state_in = srx_pkg::ST_IDLE;
               end
            end
         end

         srx_pkg::ST_OVF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srx_pkg::KIND_OVERFLOW;
               rsp_byte_in  = 8'd0;
               rsp_wake_in  = 1'b0;
               rsp_last_in  = !(brk_e_ff || bytes_e);
               rsp_more_in  = rsp_last_in && more_ff;
               if (brk_e_ff) begin
                  state_in = srx_pkg::ST_BRK;
               end else if (drain_cnt_ff != '0) begin
                  state_in = srx_pkg::ST_READ;
               end else begin
                  state_in = srx_pkg::ST_IDLE;
               end
            end
         end

         srx_pkg::ST_BRK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srx_pkg::KIND_BREAK;
               rsp_byte_in  = cfg.raw_mode ? 8'd0 : cfg.intr_char;
               rsp_wake_in  = 1'b0;
               rsp_last_in  = !bytes_e;
               rsp_more_in  = rsp_last_in && more_ff;
               state_in     = (drain_cnt_ff != '0) ? srx_pkg::ST_READ : srx_pkg::ST_IDLE;
            end
         end

         srx_pkg::ST_READ: begin
            mem_rd       = 1'b1;
            rp_in        = rp_nxt;
            drain_cnt_in = drain_cnt_ff - 1'b1;
            state_in     = srx_pkg::ST_BYTE;
         end

         srx_pkg::ST_BYTE: begin
            if (!cfg.line_open) begin
               // closed line: byte is consumed without a result
               if (drain_cnt_ff != '0) begin
                  state_in = srx_pkg::ST_READ;
               end else begin
                  state_in = done_ff ? srx_pkg::ST_DONE : srx_pkg::ST_IDLE;
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srx_pkg::KIND_BYTE;
               rsp_byte_in  = rd_data_ff;
               rsp_wake_in  = 1'b0;
               rsp_last_in  = (drain_cnt_ff == '0);
               rsp_more_in  = rsp_last_in && more_ff;
               state_in     = (drain_cnt_ff != '0) ? srx_pkg::ST_READ : srx_pkg::ST_IDLE;
            end
         end

         srx_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srx_pkg::KIND_ACK;
               rsp_byte_in  = 8'd0;
               rsp_wake_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_more_in  = more_ff;
               state_in     = srx_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = srx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srx_pkg::ST_IDLE;
         wp_ff         <= '0;
         rp_ff         <= '0;
         wake_cnt_ff   <= '0;
         saved_brk_ff  <= 1'b0;
         brk_pend_ff   <= 1'b0;
         stat_pend_ff  <= 1'b0;
         ovr_pend_ff   <= 1'b0;
         carrier_on_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         wake_cnt_ff   <= wake_cnt_in;
         saved_brk_ff  <= saved_brk_in;
         brk_pend_ff   <= brk_pend_in;
         stat_pend_ff  <= stat_pend_in;
         ovr_pend_ff   <= ovr_pend_in;
         carrier_on_ff <= carrier_on_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      svc_brk_ff   <= svc_brk_in;
      svc_car_ff   <= svc_car_in;
      car_e_ff     <= car_e_in;
      car_up_ff    <= car_up_in;
      ovf_e_ff     <= ovf_e_in;
      brk_e_ff     <= brk_e_in;
      more_ff      <= more_in;
      done_ff      <= done_in;
      drain_cnt_ff <= drain_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_wake_ff  <= rsp_wake_in;
      rsp_more_ff  <= rsp_more_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         ring_mem[wp_ff] <= q_item.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff <= ring_mem[rp_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_wake         = rsp_wake_ff;
   assign rsp_more_pending = rsp_more_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
